@@ design/pdrq_pkg.sv @@
// Package: shared constants and types for the polynomial divrem-by-constant block.
package pdrq_pkg;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned MAX_LEN_DEF = 65536;

    // Operation codes for the shared arithmetic unit.
    localparam logic [1:0] OP_MOD = 2'd0;   // x mod y
    localparam logic [1:0] OP_MUL = 2'd1;   // x * y mod n
    localparam logic [1:0] OP_DIV = 2'd2;   // x / y, x mod y

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_sts_t;
endpackage

@@ design/pdrq_alu.sv @@
// Shared bit-serial unit: restoring divide (quotient and remainder) and modular multiply.
module pdrq_alu (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pdrq_pkg::alu_cmd_t                cmd,
    input  logic [pdrq_pkg::DATA_W-1:0]       op_x,
    input  logic [pdrq_pkg::DATA_W-1:0]       op_y,
    input  logic [pdrq_pkg::DATA_W-1:0]       op_n,
    output pdrq_pkg::alu_sts_t                sts,
    output logic [pdrq_pkg::DATA_W-1:0]       res_q,
    output logic [pdrq_pkg::DATA_W-1:0]       res_r
);
    localparam int unsigned W = pdrq_pkg::DATA_W;
    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [1:0]    op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  x_reg, x_next;     // shifting operand (dividend / multiplier)
    logic [W-1:0]  y_reg, y_next;     // divisor or multiplicand
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  acc_reg, acc_next; // partial remainder / product
    logic [W-1:0]  q_reg, q_next;

    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W-1:0]  mul_step;
    logic [W:0]    trial;

    always_comb begin
        // modular multiply step: r = 2r mod n, then + y if bit set
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n_reg}) ? dbl - {1'b0, n_reg} : dbl;
        sum     = dbl_red + {1'b0, y_reg};
        if (x_reg[W-1]) begin
            mul_step = (sum >= {1'b0, n_reg}) ? W'(sum - {1'b0, n_reg}) : sum[W-1:0];
        end else begin
            mul_step = dbl_red[W-1:0];
        end
        // restoring divide step
        trial = {acc_reg, x_reg[W-1]};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        n_next    = n_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = '0;
            x_next    = op_x;
            y_next    = op_y;
            n_next    = op_n;
            acc_next  = '0;
            q_next    = '0;
        end else if (busy_reg) begin
            x_next   = {x_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (op_reg == pdrq_pkg::OP_MUL) begin
                acc_next = mul_step;
            end else begin
                if (trial >= {1'b0, y_reg}) begin
                    acc_next = W'(trial - {1'b0, y_reg});
                    q_next   = {q_reg[W-2:0], 1'b1};
                end else begin
                    acc_next = trial[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
            end
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res_q    = q_reg;
    assign res_r    = acc_reg;

    property p_done_after_busy;
        @(posedge aclk) disable iff (!aresetn) sts.done |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("alu done without busy");

    property p_mul_lt_n;
        @(posedge aclk) disable iff (!aresetn)
            (sts.done && op_reg == pdrq_pkg::OP_MUL) |-> (acc_reg < n_reg);
    endproperty
    a_mul_lt_n: assert property (p_mul_lt_n)
        else $error("modular product not reduced");

    property p_no_start_busy;
        @(posedge aclk) disable iff (!aresetn) busy_reg |-> !cmd.start;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy)
        else $error("alu restarted while busy");
endmodule

@@ design/poly_divrem_const_quotient_mod_n.sv @@
// Top level: streamed degree-zero-quotient polynomial division modulo n.
//
//  channel | ports                                   | direction
//  s_      | s_coef_a, s_coef_b, s_last              | request in
//  m_      | m_kind, m_value, m_remainder_length,    | result out
//          | m_error, m_done_res                     |
//  cfg     | cfg_valid, cfg_ready, cfg_data (modulus)| register write
//
//  Each request runs on one shared bit-serial unit.
//  Remainder request: reduce a, reduce b, one modular multiply, subtract.
//  Leading request: two reductions, then per extended Euclid round one
//  divide, one reduce and one multiply (up to ~93 rounds), then the
//  quotient multiply.
//  Reset (aresetn low, synchronous) clears control; modulus resets to 2.
//  A finished result moves into the output register once that register is
//  free or being drained; the next request is taken right after that.
module poly_divrem_const_quotient_mod_n #(
    parameter int unsigned MAX_LEN = pdrq_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pdrq_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pdrq_pkg::DATA_W-1:0]   s_coef_a,
    input  logic [pdrq_pkg::DATA_W-1:0]   s_coef_b,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [pdrq_pkg::DATA_W-1:0]   m_value,
    output logic [pdrq_pkg::LEN_W-1:0]    m_remainder_length,
    output logic                          m_error,
    output logic                          m_done_res
);
    localparam int unsigned W  = pdrq_pkg::DATA_W;
    localparam int unsigned LW = pdrq_pkg::LEN_W;
    localparam int unsigned CAP_RAW = MAX_LEN - 1;
    localparam logic [LW-1:0] CAP = (CAP_RAW > 65535) ? LW'(65535) : LW'(CAP_RAW);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RED_A = 4'd1;  // a mod n
    localparam logic [3:0] ST_RED_B = 4'd2;  // b mod n
    localparam logic [3:0] ST_EU_CK = 4'd3;  // check r1, start divide
    localparam logic [3:0] ST_EU_DV = 4'd4;  // r0 / r1
    localparam logic [3:0] ST_EU_QM = 4'd5;  // q mod n
    localparam logic [3:0] ST_EU_ML = 4'd6;  // (q mod n) * t1 mod n
    localparam logic [3:0] ST_QMUL  = 4'd7;  // a * inv mod n
    localparam logic [3:0] ST_RMUL  = 4'd8;  // q * b mod n
    localparam logic [3:0] ST_OUT   = 4'd9;  // hand to output register
    localparam logic [3:0] ST_WAIT  = 4'd10; // wait for output slot

    logic [3:0]    st_reg, st_next;
    logic [W-1:0]  mod_reg;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next;
    logic          last_reg;
    logic [W-1:0]  r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0]  t0_reg, t0_next, t1_reg, t1_next;
    logic [W-1:0]  val_reg, val_next;
    logic          lead_reg, lead_next;
    logic          nz_reg, nz_next;
    logic [LW-1:0] len_reg, len_next;
    logic          err_reg, err_next;
    logic [W-1:0]  quot_reg, quot_next;
    // Euclid success marker: set when the quotient multiply path was taken.
    logic          qok_reg;

    // output register
    logic          ov_reg, ov_next;
    logic          ok_reg, ok_next;
    logic [W-1:0]  oval_reg, oval_next;
    logic [LW-1:0] olen_reg, olen_next;
    logic          oerr_reg, oerr_next;
    logic          odone_reg, odone_next;

    pdrq_pkg::alu_cmd_t cmd;
    pdrq_pkg::alu_sts_t sts;
    logic [W-1:0] op_x, op_y, res_q, res_r;
    logic         n_ok;

    pdrq_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op_x    (op_x),
        .op_y    (op_y),
        .op_n    (mod_reg),
        .sts     (sts),
        .res_q   (res_q),
        .res_r   (res_r)
    );

    assign n_ok      = (mod_reg > W'(1));
    assign s_ready   = (st_reg == ST_IDLE);
    assign cfg_ready = (st_reg == ST_IDLE);

    always_comb begin
        st_next    = st_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        val_next   = val_reg;
        lead_next  = lead_reg;
        nz_next    = nz_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        quot_next  = quot_reg;
        ov_next    = ov_reg && !m_ready;
        ok_next    = ok_reg;
        oval_next  = oval_reg;
        olen_next  = olen_reg;
        oerr_next  = oerr_reg;
        odone_next = odone_reg;
        cmd.start  = 1'b0;
        cmd.op     = pdrq_pkg::OP_MOD;
        op_x       = a_reg;
        op_y       = mod_reg;

        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next = s_coef_a;
                    b_next = s_coef_b;
                    if (n_ok) begin
                        cmd.start = 1'b1;
                        op_x      = s_coef_a;
                        st_next   = ST_RED_A;
                    end else begin
                        a_next  = '0;
                        b_next  = '0;
                        st_next = ST_OUT;
                    end
                end
            end
            ST_RED_A: begin
                if (sts.done) begin
                    a_next    = res_r;
                    cmd.start = 1'b1;
                    op_x      = b_reg;
                    st_next   = ST_RED_B;
                end
            end
            ST_RED_B: begin
                if (sts.done) begin
                    b_next = res_r;
                    if (lead_reg) begin
                        r0_next = mod_reg;
                        r1_next = res_r;
                        t0_next = '0;
                        t1_next = W'(1);
                        st_next = ST_EU_CK;
                    end else if (err_reg) begin
                        st_next = ST_OUT;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.op    = pdrq_pkg::OP_MUL;
                        op_x      = res_r;
                        op_y      = quot_reg;
                        st_next   = ST_RMUL;
                    end
                end
            end
            ST_EU_CK: begin
                if (r1_reg == '0) begin
                    if (r0_reg == W'(1)) begin
                        cmd.start = 1'b1;
                        cmd.op    = pdrq_pkg::OP_MUL;
                        op_x      = t0_reg;
                        op_y      = a_reg;
                        st_next   = ST_QMUL;
                    end else begin
                        st_next = ST_OUT;
                    end
                end else begin
                    cmd.start = 1'b1;
                    cmd.op    = pdrq_pkg::OP_DIV;
                    op_x      = r0_reg;
                    op_y      = r1_reg;
                    st_next   = ST_EU_DV;
                end
            end
            ST_EU_DV: begin
                if (sts.done) begin
                    r0_next   = r1_reg;
                    r1_next   = res_r;
                    cmd.start = 1'b1;
                    op_x      = res_q;
                    st_next   = ST_EU_QM;
                end
            end
            ST_EU_QM: begin
                if (sts.done) begin
                    cmd.start = 1'b1;
                    cmd.op    = pdrq_pkg::OP_MUL;
                    op_x      = t1_reg;   // multiplier bits
                    op_y      = res_r;
                    st_next   = ST_EU_ML;
                end
            end
            ST_EU_ML: begin
                if (sts.done) begin
                    t0_next = t1_reg;
                    t1_next = (t0_reg >= res_r) ? t0_reg - res_r
                                                : t0_reg - res_r + mod_reg;
                    st_next = ST_EU_CK;
                end
            end
            ST_QMUL: begin
                if (sts.done) begin
                    val_next = res_r;
                    st_next  = ST_OUT;
                end
            end
            ST_RMUL: begin
                if (sts.done) begin
                    val_next = (a_reg >= res_r) ? a_reg - res_r
                                                : a_reg - res_r + mod_reg;
                    st_next  = ST_OUT;
                end
            end
            ST_OUT, ST_WAIT: begin
                if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                    if (lead_reg) begin
                        // quotient result: error when Euclid did not reach 1
                        // or the modulus is below two
                        ok_next   = 1'b0;
                        if (n_ok && qok_reg) begin
                            oerr_next = 1'b0;
                            oval_next = val_reg;
                            quot_next = val_reg;
                            err_next  = 1'b0;
                        end else begin
                            oerr_next = 1'b1;
                            oval_next = '0;
                            quot_next = '0;
                            err_next  = 1'b1;
                        end
                        olen_next = '0;
                        nz_next   = 1'b0;
                        len_next  = '0;
                        lead_next = 1'b0;
                    end else begin
                        ok_next   = 1'b1;
                        oerr_next = err_reg || !n_ok;
                        oval_next = (err_reg || !n_ok) ? '0 : val_reg;
                        if (nz_reg || (!(err_reg || !n_ok) && val_reg != '0)) begin
                            nz_next = 1'b1;
                            if (len_reg < CAP) len_next = len_reg + 1'b1;
                            olen_next = (len_reg < CAP) ? len_reg + 1'b1 : len_reg;
                        end else begin
                            olen_next = len_reg;
                        end
                    end
                    odone_next = last_reg;
                    if (!last_reg) begin
                        olen_next = '0;
                    end else begin
                        lead_next = 1'b1;
                        nz_next   = 1'b0;
                        len_next  = '0;
                        err_next  = 1'b0;
                    end
                end else begin
                    st_next = ST_WAIT;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            mod_reg  <= W'(2);
            lead_reg <= 1'b1;
            nz_reg   <= 1'b0;
            len_reg  <= '0;
            err_reg  <= 1'b0;
            quot_reg <= '0;
            ov_reg   <= 1'b0;
            qok_reg  <= 1'b0;
        end else begin
            st_reg   <= st_next;
            lead_reg <= lead_next;
            nz_reg   <= nz_next;
            len_reg  <= len_next;
            err_reg  <= err_next;
            quot_reg <= quot_next;
            ov_reg   <= ov_next;
            if (cfg_valid && cfg_ready) mod_reg <= cfg_data;
            if (st_reg == ST_IDLE) qok_reg <= 1'b0;
            else if (st_reg == ST_QMUL && sts.done) qok_reg <= 1'b1;
        end
        if (s_valid && s_ready) last_reg <= s_last;
        a_reg     <= a_next;
        b_reg     <= b_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        val_reg   <= val_next;
        ok_reg    <= ok_next;
        oval_reg  <= oval_next;
        olen_reg  <= olen_next;
        oerr_reg  <= oerr_next;
        odone_reg <= odone_next;
    end

    assign m_valid            = ov_reg;
    assign m_kind             = ok_reg;
    assign m_value            = oval_reg;
    assign m_remainder_length = olen_reg;
    assign m_error            = oerr_reg;
    assign m_done_res         = odone_reg;

    property p_len_only_done;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_done_res) |-> (m_remainder_length == '0);
    endproperty
    a_len_only_done: assert property (p_len_only_done)
        else $error("length shown on non-final result");

    property p_err_zero;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && m_error) |-> (m_value == '0);
    endproperty
    a_err_zero: assert property (p_err_zero)
        else $error("nonzero value on error result");

    property p_busy_not_ready;
        @(posedge aclk) disable iff (!aresetn) sts.busy |-> !s_ready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready)
        else $error("request taken while unit busy");
endmodule

@@ dv/pdrq_result_checker.sv @@
// Result checker: watches the channels, predicts each result and compares it.
module pdrq_result_checker #(
    parameter int unsigned MAX_LEN = pdrq_pkg::MAX_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [pdrq_pkg::DATA_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [pdrq_pkg::DATA_W-1:0] s_coef_a,
    input  logic [pdrq_pkg::DATA_W-1:0] s_coef_b,
    input  logic                        s_last,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_kind,
    input  logic [pdrq_pkg::DATA_W-1:0] m_value,
    input  logic [pdrq_pkg::LEN_W-1:0]  m_remainder_length,
    input  logic                        m_error,
    input  logic                        m_done_res,
    output int                          fail_count,
    output int                          pending_count
);
    localparam int unsigned DW = pdrq_pkg::DATA_W;
    localparam int unsigned LW = pdrq_pkg::LEN_W;
    localparam logic KIND_QUOT = 1'b0;
    localparam logic KIND_REM  = 1'b1;
    localparam int unsigned LEN_CAP = (MAX_LEN - 1 > 65535) ? 65535 : MAX_LEN - 1;

    typedef struct packed {
        logic          kind;
        logic [DW-1:0] value;
        logic [LW-1:0] rlen;
        logic          error;
        logic          done;
    } coef_result_t;

    coef_result_t  coef_q[$];
    logic [DW-1:0] modulus;
    logic [DW-1:0] quot;
    logic          leading;
    logic          nz_seen;
    int unsigned   rem_len;
    logic          bad_div;

    function automatic logic [DW-1:0] add_mod(logic [DW-1:0] x, y, n);
        logic [DW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] sub_mod(logic [DW-1:0] x, y, n);
        return (x >= y) ? x - y : x - y + n;
    endfunction

    function automatic logic [DW-1:0] mul_mod(logic [DW-1:0] x, y, n);
        logic [DW-1:0] r;
        r = '0;
        for (int i = DW - 1; i >= 0; i--) begin
            r = add_mod(r, r, n);
            if (y[i]) r = add_mod(r, x, n);
        end
        return r;
    endfunction

    // extended Euclid; ok = 0 when gcd(b, n) != 1
    function automatic logic [DW-1:0] inv_mod(logic [DW-1:0] b, n, output logic ok);
        logic [DW-1:0] r0, r1, t0, t1, qq, rn, tn;
        r0 = n; r1 = b; t0 = '0; t1 = DW'(1);
        while (r1 != 0) begin
            qq = r0 / r1;
            rn = r0 - qq * r1;
            tn = sub_mod(t0, mul_mod(qq % n, t1, n), n);
            r0 = r1; r1 = rn;
            t0 = t1; t1 = tn;
        end
        ok = (r0 == 1);
        return t0;
    endfunction

    task automatic predict_coef(logic [DW-1:0] ca, cb, logic lst);
        coef_result_t  res;
        logic [DW-1:0] a, b, inv;
        logic          ok;
        res = '0;
        a = '0; b = '0;
        if (modulus >= 2) begin
            a = ca % modulus;
            b = cb % modulus;
        end
        if (leading) begin
            res.kind = KIND_QUOT;
            bad_div = 1'b0;
            quot = '0;
            ok = 1'b0;
            if (modulus >= 2) inv = inv_mod(b, modulus, ok);
            if (ok) begin
                quot = mul_mod(a, inv, modulus);
                res.value = quot;
            end else begin
                bad_div = 1'b1;
            end
            nz_seen = 1'b0;
            rem_len = 0;
            leading = 1'b0;
        end else begin
            res.kind = KIND_REM;
            if (!bad_div) res.value = sub_mod(a, mul_mod(quot, b, modulus), modulus);
            if (nz_seen || res.value != 0) begin
                nz_seen = 1'b1;
                if (rem_len < LEN_CAP) rem_len++;
            end
        end
        res.rlen  = lst ? rem_len[LW-1:0] : '0;
        res.error = bad_div;
        res.done  = lst;
        if (lst) begin
            leading = 1'b1;
            nz_seen = 1'b0;
            rem_len = 0;
            bad_div = 1'b0;
        end
        coef_q.push_back(res);
    endtask

    always @(posedge aclk) begin
        coef_result_t want;
        if (!aresetn) begin
            coef_q.delete();
            fail_count = 0;
            modulus = DW'(2);
            quot = '0;
            leading = 1'b1;
            nz_seen = 1'b0;
            rem_len = 0;
            bad_div = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (coef_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d value=%h", $time, m_kind, m_value);
                    fail_count++;
                end else begin
                    want = coef_q.pop_front();
                    if (m_kind !== want.kind) begin
                        $display("%0t: kind exp %0d got %0d", $time, want.kind, m_kind);
                        fail_count++;
                    end
                    if (m_value !== want.value) begin
                        $display("%0t: value exp %h got %h", $time, want.value, m_value);
                        fail_count++;
                    end
                    if (m_remainder_length !== want.rlen) begin
                        $display("%0t: remainder_length exp %0d got %0d",
                                 $time, want.rlen, m_remainder_length);
                        fail_count++;
                    end
                    if (m_error !== want.error) begin
                        $display("%0t: error exp %0d got %0d", $time, want.error, m_error);
                        fail_count++;
                    end
                    if (m_done_res !== want.done) begin
                        $display("%0t: done_res exp %0d got %0d", $time, want.done, m_done_res);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) modulus = cfg_data;
            if (s_valid && s_ready) predict_coef(s_coef_a, s_coef_b, s_last);
        end
        pending_count = coef_q.size();
    end
endmodule

@@ dv/poly_divrem_const_quotient_mod_n_test.sv @@
// Testbench top: stimulus, idling, configuration phases and the verdict.
module poly_divrem_const_quotient_mod_n_test;
    localparam int unsigned DW = pdrq_pkg::DATA_W;
    localparam int unsigned LW = pdrq_pkg::LEN_W;

    // Worst case per request is a leading pair plus
    // receiver stalls; this ceiling is several times the slowest clean run.
    localparam longint CYCLE_LIMIT = 200_000_000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [DW-1:0] cfg_data = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [DW-1:0] s_coef_a = '0;
    logic [DW-1:0] s_coef_b = '0;
    logic          s_last = 1'b0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_kind;
    logic [DW-1:0] m_value;
    logic [LW-1:0] m_remainder_length;
    logic          m_error;
    logic          m_done_res;

    int            fail_count;
    int            pending_count;
    longint        cycle_cnt = 0;
    logic [DW-1:0] cur_mod = 2;   // modulus as last written, for shaping stimulus
    int            burst_left = 0;
    int unsigned   req_sent = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    poly_divrem_const_quotient_mod_n uut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_coef_a, .s_coef_b, .s_last,
        .m_valid, .m_ready, .m_kind, .m_value, .m_remainder_length,
        .m_error, .m_done_res
    );

    pdrq_result_checker chk (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_coef_a, .s_coef_b, .s_last,
        .m_valid, .m_ready, .m_kind, .m_value, .m_remainder_length,
        .m_error, .m_done_res, .fail_count, .pending_count
    );

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: the style changes when stall_cnt[8:0] wraps -
    // always ready, coin flip, mostly stalled, or long on/off stretches.
    logic [1:0]  stall_mode = 2'd0;
    logic [31:0] stall_cnt = '0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt[8:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= ($urandom_range(0, 9) == 0);
            default: m_ready <= stall_cnt[6];
        endcase
    end

    function automatic logic [DW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // coefficient already reduced below the current modulus
    function automatic logic [DW-1:0] rand_coef();
        logic [DW-1:0] x;
        x = rand64();
        return (cur_mod >= 2) ? x % cur_mod : x;
    endfunction

    // Hold the request until accepted. Bursts: when a burst runs out the
    // channel may go quiet for a random gap before the next one starts.
    task automatic send_pair(logic [DW-1:0] a, b, logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_last   <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        req_sent++;
    endtask

    task automatic write_modulus(logic [DW-1:0] n);
        // only while idle: all results back
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_mod = n;
    endtask

    // One polynomial. shape: 0 random, 1 a==b on leading pairs (q=1, zero
    // remainder head), 2 a==0 leading (q=0), 3 leading b likely not invertible,
    // 4 unreduced full-width coefficients.
    task automatic send_poly(int len, int shape);
        logic [DW-1:0] a, b;
        int zhead;
        zhead = $urandom_range(0, len);
        for (int i = 0; i < len; i++) begin
            b = rand_coef();
            a = rand_coef();
            case (shape)
                1: if (i <= zhead) a = b;
                2: if (i <= zhead) a = '0;
                3: if (i == 0) b = ($urandom_range(0, 1) != 0) ? '0 : (b & ~64'd1);
                4: begin a = rand64(); b = rand64(); end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic random_phase(logic [DW-1:0] n, int unsigned items);
        int unsigned stop_at;
        int len, pick;
        write_modulus(n);
        stop_at = req_sent + items;
        while (req_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            len = (pick < 14) ? $urandom_range(1, 6) :
                  (pick < 19) ? $urandom_range(7, 30) : 1;
            pick = $urandom_range(0, 19);
            send_poly(len, (pick < 11) ? 0 : (pick < 14) ? 1 : (pick < 16) ? 2 :
                           (pick < 18) ? 3 : 4);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset modulus 2, single pair and short polynomials.
        send_pair(64'd1, 64'd1, 1'b1);
        send_pair(64'd1, 64'd0, 1'b0);          // leading b = 0: error
        send_pair(64'd1, 64'd1, 1'b1);
        send_pair(64'd5, 64'd3, 1'b0);          // unreduced at n = 2
        send_pair(64'd3, 64'd1, 1'b0);
        send_pair('1, '1, 1'b1);
        write_modulus('1);                      // largest modulus
        send_pair('1 - 1, '1 - 1, 1'b0);
        send_pair('1 - 1, 64'd1, 1'b0);
        send_pair('1, '1, 1'b1);                // unreduced: both reduce to 0
        send_pair(64'd3, 64'd3, 1'b1);          // gcd 3 with 2^64-1: error
        write_modulus(64'd12);                  // composite modulus
        send_pair(64'd7, 64'd4, 1'b0);          // b = 4 not invertible
        send_pair(64'd5, 64'd3, 1'b1);
        send_pair(64'd7, 64'd5, 1'b0);
        send_pair(64'd10, 64'd5, 1'b0);         // first remainder coefficient is nonzero
        send_pair(64'd1, 64'd2, 1'b1);
        write_modulus(64'd0);                   // modulus below two
        send_pair(64'd3, 64'd1, 1'b0);
        send_pair(64'd2, 64'd2, 1'b1);
        write_modulus(64'd1);
        send_pair(64'd1, 64'd1, 1'b1);
        write_modulus(64'h8000_0000_0000_0000);
        send_pair('1, 64'd3, 1'b0);
        send_pair(64'd0, 64'h7fff_ffff_ffff_ffff, 1'b1);

        // Random phases over several moduli, the extremes among them.
        random_phase(64'd7, 250);
        random_phase(rand64() | 64'd1, 400);
        random_phase('1, 300);
        random_phase(64'h8000_0000_0000_0000, 200);
        random_phase(64'd2, 150);
        random_phase(64'($urandom_range(3, 1000)), 300);
        random_phase(64'hffff_ffff_ffff_ffc5, 400);   // large prime

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
